### rtl/core/ctlex_pkg.sv
// Shared types, codes and character classes for the config text lexer.
package ctlex_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int TOKEN_BITS        = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [TOKEN_BITS-1:0] LEN_MAX = '1;

    // token kinds
    localparam logic [2:0] K_END     = 3'd0;
    localparam logic [2:0] K_COMMAND = 3'd1;
    localparam logic [2:0] K_BRACE   = 3'd2;
    localparam logic [2:0] K_COMMENT = 3'd3;
    localparam logic [2:0] K_IDENT   = 3'd4;
    localparam logic [2:0] K_HEX     = 3'd5;
    localparam logic [2:0] K_DIGITS  = 3'd6;
    localparam logic [2:0] K_UNKNOWN = 3'd7;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    typedef struct packed {
        logic [2:0]            kind;
        logic [TOKEN_BITS-1:0] start;
        logic [TOKEN_BITS-1:0] length;
    } t_token;

    // everything one text byte produces: one or two tokens
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_rec;

    function automatic logic is_eol(input logic [7:0] c);
        return (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || is_eol(c);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

### rtl/core/config_text_lexer.sv
// Top level of the config text lexer: streaming byte-in, token-out scanner.
//
// Streaming lexer for configuration text. One text byte is pushed per beat
// (i_push while o_full is low); byte 0 ends the stream, emits an end token and
// restarts the offset at 0. Tokens come out as kind, start offset, length and
// a last_of_run flag marking the final token caused by a byte; a byte that
// closes an open token also starts the next, so it can cause two tokens. The
// front end takes one byte every cycle while the queue is not full and needs
// one mode transition per byte; a byte's tokens pass through the queue and the
// back end's output register. The back end presents one token per cycle while
// i_pop is high, so a byte that causes two tokens holds the output for both;
// a four-record queue between the halves absorbs this, and o_full rises only
// when output stalls or double-token bytes outrun one token per cycle.
// Lengths saturate at 65535; offsets wrap modulo 2^POSITION_BITS and only the
// low 16 bits are reported. No clearing pass after reset.
module config_text_lexer #(
    parameter int POSITION_BITS = ctlex_pkg::POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [2:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import ctlex_pkg::*;

    logic w_f_push;
    t_rec w_f_rec;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    t_rec w_q_rec;

    // front end stalls only on a full queue
    assign o_full = w_q_full;

    ctlex_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_text_byte (i_text_byte),
        .i_full      (w_q_full),
        .o_push      (w_f_push),
        .o_rec       (w_f_rec)
    );

    ctlex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_rec   (w_f_rec),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_rec   (w_q_rec)
    );

    ctlex_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_q_rec        (w_q_rec),
        .o_q_pop        (w_q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

### rtl/core/ctlex_front.sv
// Front end: classifies each byte, runs the lexer mode machine, builds token records.
module ctlex_front #(
    parameter int POSITION_BITS = ctlex_pkg::POSITION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_text_byte,
    input  logic            i_full,
    output logic            o_push,
    output ctlex_pkg::t_rec o_rec
);
    import ctlex_pkg::*;

    localparam int EXT_W = (POSITION_BITS > TOKEN_BITS) ? POSITION_BITS : TOKEN_BITS;

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_CMD_LEAD = 4'd1;
    localparam logic [3:0] M_CMD_BODY = 4'd2;
    localparam logic [3:0] M_CMD_ESC  = 4'd3;
    localparam logic [3:0] M_COMMENT  = 4'd4;
    localparam logic [3:0] M_IDENT    = 4'd5;
    localparam logic [3:0] M_ZERO     = 4'd6;
    localparam logic [3:0] M_HEX      = 4'd7;
    localparam logic [3:0] M_DIGITS   = 4'd8;

    logic [3:0]               r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [TOKEN_BITS-1:0]    r_start, n_start;
    logic [TOKEN_BITS-1:0]    r_len, n_len;

    logic                     w_accept;
    logic [7:0]               b;
    logic [POSITION_BITS-1:0] w_pos_inc;
    logic [EXT_W-1:0]         w_pos_ext, w_inc_ext;
    logic [TOKEN_BITS-1:0]    w_p16, w_inc16, w_grown;
    logic                     w_rescan, w_e1_v, w_e2_v;
    t_token                   w_e1, w_e2;

    assign w_accept  = i_push && !i_full;
    assign b         = i_text_byte;
    assign w_pos_inc = r_pos + 1'b1;
    assign w_pos_ext = EXT_W'(r_pos);
    assign w_inc_ext = EXT_W'(w_pos_inc);
    assign w_p16     = w_pos_ext[TOKEN_BITS-1:0];
    assign w_inc16   = w_inc_ext[TOKEN_BITS-1:0];
    assign w_grown   = (r_len != LEN_MAX) ? r_len + 1'b1 : r_len;

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = w_pos_inc;
        w_rescan = 1'b0;
        w_e1_v   = 1'b0;
        w_e1     = '{kind: K_COMMAND, start: r_start, length: r_len};
        w_e2_v   = 1'b0;
        w_e2     = '{kind: K_END, start: w_p16, length: TOKEN_BITS'(1)};

        // continue the open token
        unique case (r_mode)
            M_CMD_LEAD: begin
                if (b == CH_NUL) begin
                    w_e1_v   = 1'b1;
                    w_e1     = '{kind: K_COMMAND, start: w_p16, length: '0};
                    w_rescan = 1'b1;
                end else if (!is_space(b)) begin
                    n_start = w_p16;
                    n_len   = TOKEN_BITS'(1);
                    n_mode  = (b == CH_BSLASH) ? M_CMD_ESC : M_CMD_BODY;
                end
            end
            M_CMD_BODY: begin
                if (b == CH_NUL || is_eol(b)) begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end else begin
                    n_len = w_grown;
                    if (b == CH_BSLASH) n_mode = M_CMD_ESC;
                end
            end
            M_CMD_ESC: begin
                if (b == CH_NUL) begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end else begin
                    n_len  = w_grown;
                    n_mode = M_CMD_BODY;
                end
            end
            M_COMMENT: begin
                w_e1.kind = K_COMMENT;
                if (b == CH_NUL || is_eol(b)) begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end else begin
                    n_len = w_grown;
                end
            end
            M_IDENT: begin
                w_e1.kind = K_IDENT;
                if (is_alpha(b) || is_digit(b)) begin
                    n_len = w_grown;
                end else begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end
            end
            M_ZERO: begin
                w_e1.kind = K_DIGITS;
                if (b == CH_X_LO || b == CH_X_UP) begin
                    n_len  = w_grown;
                    n_mode = M_HEX;
                end else if (is_digit(b) || b == CH_DOT) begin
                    n_len  = w_grown;
                    n_mode = M_DIGITS;
                end else begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end
            end
            M_HEX: begin
                w_e1.kind = K_HEX;
                if (is_hex(b)) begin
                    n_len = w_grown;
                end else begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end
            end
            M_DIGITS: begin
                w_e1.kind = K_DIGITS;
                if (is_digit(b) || b == CH_DOT) begin
                    n_len = w_grown;
                end else begin
                    w_e1_v   = 1'b1;
                    w_rescan = 1'b1;
                end
            end
            default: begin
                // idle and unused codes
                w_rescan = 1'b1;
            end
        endcase

        // byte starts a new token
        if (w_rescan) begin
            n_mode = M_IDLE;
            priority if (b == CH_NUL) begin
                w_e2_v = 1'b1;
                w_e2   = '{kind: K_END, start: w_p16, length: TOKEN_BITS'(1)};
                n_pos  = '0;
            end else if (is_space(b)) begin
                n_mode = M_IDLE;
            end else if (b == CH_COLON) begin
                n_mode = M_CMD_LEAD;
            end else if (b == CH_RBRACE) begin
                w_e2_v = 1'b1;
                w_e2   = '{kind: K_BRACE, start: w_p16, length: TOKEN_BITS'(1)};
            end else if (b == CH_HASH) begin
                n_start = w_inc16;
                n_len   = '0;
                n_mode  = M_COMMENT;
            end else if (is_alpha(b)) begin
                n_start = w_p16;
                n_len   = TOKEN_BITS'(1);
                n_mode  = M_IDENT;
            end else if (is_digit(b)) begin
                n_start = w_p16;
                n_len   = TOKEN_BITS'(1);
                n_mode  = (b == CH_ZERO) ? M_ZERO : M_DIGITS;
            end else begin
                w_e2_v = 1'b1;
                w_e2   = '{kind: K_UNKNOWN, start: w_p16, length: TOKEN_BITS'(1)};
            end
        end
    end

    always_comb begin
        o_push    = w_accept && (w_e1_v || w_e2_v);
        o_rec.tok0 = w_e1_v ? w_e1 : w_e2;
        o_rec.tok1 = w_e2;
        o_rec.two  = w_e1_v && w_e2_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    // NUL always closes the stream
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_text_byte == CH_NUL) |=> (r_pos == '0 && r_mode == M_IDLE))
        else $error("NUL did not restart the stream");

    a_two_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_rec.two) |-> (r_mode != M_IDLE))
        else $error("two tokens from one byte while idle");

endmodule

### rtl/core/ctlex_queue.sv
// Small register queue of token records between front and back.
module ctlex_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ctlex_pkg::t_rec i_rec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ctlex_pkg::t_rec o_rec
);
    import ctlex_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rec     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + 1'b1;
            if (w_do_pop)  r_rd <= r_rd + 1'b1;
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_wr - r_rd) == r_cnt[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

### rtl/core/ctlex_back.sv
// Back end: output register, splits each record into one or two result beats.
module ctlex_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  ctlex_pkg::t_rec i_q_rec,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [2:0]      o_token_kind,
    output logic [15:0]     o_token_start,
    output logic [15:0]     o_token_length,
    output logic            o_last_of_run
);
    import ctlex_pkg::*;

    logic   r_valid;
    logic   r_sel;
    t_rec   r_rec;
    t_token w_tok;
    logic   w_last, w_take;

    assign w_tok          = r_sel ? r_rec.tok1 : r_rec.tok0;
    assign w_last         = r_sel || !r_rec.two;
    assign w_take         = r_valid && i_pop;
    assign o_q_pop        = !i_q_empty && (!r_valid || (w_take && w_last));
    assign o_empty        = !r_valid;
    assign o_token_kind   = w_tok.kind;
    assign o_token_start  = w_tok.start;
    assign o_token_length = w_tok.length;
    assign o_last_of_run  = w_last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_rec <= i_q_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_valid <= 1'b1;
                r_sel   <= 1'b0;
            end else if (w_take) begin
                r_valid <= !w_last;
                r_sel   <= !w_last;
            end
        end
    end

    a_sel_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sel) |-> r_rec.two)
        else $error("second beat of a single-token record");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_sel)))
        else $error("result changed while stalled");

endmodule
